FILE: rtl/nine_channel_biquad_lowpass_defines.svh
// Assertion macros for the RTL of the biquad block; only nclp_ctrl.sv includes them.
// NCLP_ASSERT checks a property with reset as a disable condition.
// NCLP_ASSERT_ALWAYS checks a property at every rising clock edge, reset included.
`ifndef NINE_CHANNEL_BIQUAD_LOWPASS_DEFINES_SVH
`define NINE_CHANNEL_BIQUAD_LOWPASS_DEFINES_SVH

`ifndef SYNTHESIS
`define NCLP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define NCLP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define NCLP_ASSERT(lbl, clk, rst_n, prop)
`define NCLP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/nclp_pkg.sv
`default_nettype none

package nclp_pkg;

    // Filter geometry
    localparam int CHANNELS       = 9;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_BITS      = COEF_FRAC_BITS + 2;

    // Product and accumulator widths (five products, growth of three bits)
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SH_W   = ACC_W - COEF_FRAC_BITS;

    // Stream payload
    localparam int DATA_W  = CHANNELS * SAMPLE_BITS;
    localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_reg_idx;

    // Half an LSB of the output, added before the arithmetic shift
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    // Coefficient reset values, signed Q2.16
    localparam logic signed [COEF_BITS-1:0] COEF_B0_RST = COEF_BITS'(1298);
    localparam logic signed [COEF_BITS-1:0] COEF_B1_RST = COEF_BITS'(2595);
    localparam logic signed [COEF_BITS-1:0] COEF_B2_RST = COEF_BITS'(1298);
    localparam logic signed [COEF_BITS-1:0] COEF_A1_RST = COEF_BITS'(-102531);
    localparam logic signed [COEF_BITS-1:0] COEF_A2_RST = COEF_BITS'(42186);

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } t_coef;

    // Pipeline enables from the controller to every lane
    typedef struct packed {
        logic load;   // input transfer into the product stage
        logic mv2;    // product stage to feedforward sum stage
        logic mv3;    // sum stage to feedback stage
        logic fire;   // feedback stage completes, result to output register
    } t_pipe_ctl;

endpackage

`default_nettype wire

FILE: rtl/nclp_lane.sv
`default_nettype none

module nclp_lane (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  nclp_pkg::t_pipe_ctl                      i_ctl,
    input  nclp_pkg::t_coef                          i_coef,
    input  logic signed [nclp_pkg::SAMPLE_BITS-1:0]  i_x,
    output logic signed [nclp_pkg::SAMPLE_BITS-1:0]  o_y
);

    // Channel history
    logic signed [nclp_pkg::SAMPLE_BITS-1:0] r_x1;
    logic signed [nclp_pkg::SAMPLE_BITS-1:0] r_x2;
    logic signed [nclp_pkg::SAMPLE_BITS-1:0] r_y1;
    logic signed [nclp_pkg::SAMPLE_BITS-1:0] r_y2;
    logic signed [nclp_pkg::SAMPLE_BITS-1:0] n_y2;

    // a2 times the output two back, kept ready for the next item
    logic signed [nclp_pkg::PROD_W-1:0] r_q;

    // Stage payloads
    logic signed [nclp_pkg::PROD_W-1:0] r_pb0;
    logic signed [nclp_pkg::PROD_W-1:0] r_pb1;
    logic signed [nclp_pkg::PROD_W-1:0] r_pb2;
    logic signed [nclp_pkg::ACC_W-1:0]  r_ff;
    logic signed [nclp_pkg::ACC_W-1:0]  r_fb;

    // Feedback stage
    logic signed [nclp_pkg::PROD_W-1:0] p_a1y1;
    logic signed [nclp_pkg::ACC_W-1:0]  acc;
    logic        [nclp_pkg::ACC_W-1:0]  rnd;
    logic signed [nclp_pkg::SH_W-1:0]   sh;
    logic        [nclp_pkg::SH_W-nclp_pkg::SAMPLE_BITS:0] top;
    logic                               ovf;

    // Feedforward products taken at the input transfer, their sum, and its hand-off to the feedback stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pb0 <= nclp_pkg::PROD_W'(i_coef.b0) * nclp_pkg::PROD_W'(i_x);
            r_pb1 <= nclp_pkg::PROD_W'(i_coef.b1) * nclp_pkg::PROD_W'(r_x1);
            r_pb2 <= nclp_pkg::PROD_W'(i_coef.b2) * nclp_pkg::PROD_W'(r_x2);
        end
        if (i_ctl.mv2) begin
            r_ff <= nclp_pkg::ACC_W'(r_pb0) + nclp_pkg::ACC_W'(r_pb1)
                  + nclp_pkg::ACC_W'(r_pb2);
        end
        // feedforward sum held for the feedback stage
        if (i_ctl.mv3) begin
            r_fb <= r_ff;
        end
    end

    // Feedback sum, rounding, saturation, and the y2 value for the next a2 product
    always_comb begin
        p_a1y1 = nclp_pkg::PROD_W'(i_coef.a1) * nclp_pkg::PROD_W'(r_y1);
        acc    = r_fb - nclp_pkg::ACC_W'(p_a1y1) - nclp_pkg::ACC_W'(r_q);
        rnd    = acc + nclp_pkg::ROUND_BIAS;
        sh     = $signed(rnd[nclp_pkg::ACC_W-1:nclp_pkg::COEF_FRAC_BITS]);
        top    = sh[nclp_pkg::SH_W-1:nclp_pkg::SAMPLE_BITS-1];
        ovf    = !((&top) || (~|top));
        if (ovf) begin
            o_y = {sh[nclp_pkg::SH_W-1], {(nclp_pkg::SAMPLE_BITS-1){~sh[nclp_pkg::SH_W-1]}}};
        end else begin
            o_y = sh[nclp_pkg::SAMPLE_BITS-1:0];
        end
        n_y2 = i_ctl.fire ? r_y1 : r_y2;
    end

    // History shifts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
            r_q  <= '0;
        end else begin
            if (i_ctl.load) begin
                r_x1 <= i_x;
                r_x2 <= r_x1;
            end
            if (i_ctl.fire) begin
                r_y1 <= o_y;
                r_y2 <= r_y1;
            end
            r_q <= nclp_pkg::PROD_W'(i_coef.a2) * nclp_pkg::PROD_W'(n_y2);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/nclp_ctrl.sv
`default_nettype none
`include "nine_channel_biquad_lowpass_defines.svh"

module nclp_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nclp_pkg::REG_IDX_W-1:0]   i_cfg_index,
    input  logic [nclp_pkg::COEF_BITS-1:0]   i_cfg_data,
    output nclp_pkg::t_pipe_ctl              o_ctl,
    output nclp_pkg::t_coef                  o_coef
);

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic n_v1;
    logic n_v2;
    logic n_v3;
    logic out_free;

    nclp_pkg::t_coef r_coef;
    nclp_pkg::t_coef n_coef;

    // Stage advance, each stage moves when the one ahead is free or moving
    always_comb begin
        out_free   = !i_out_valid || i_out_ready;
        o_ctl.fire = r_v3 && out_free;
        o_ctl.mv3  = r_v2 && (!r_v3 || o_ctl.fire);
        o_ctl.mv2  = r_v1 && (!r_v2 || o_ctl.mv3);
        o_in_ready = !r_v1 || o_ctl.mv2;
        o_ctl.load = i_in_valid && o_in_ready;

        n_v1 = o_ctl.load || (r_v1 && !o_ctl.mv2);
        n_v2 = o_ctl.mv2  || (r_v2 && !o_ctl.mv3);
        n_v3 = o_ctl.mv3  || (r_v3 && !o_ctl.fire);
    end

    // Register write decode
    always_comb begin
        n_coef = r_coef;
        if (i_cfg_valid) begin
            unique case (nclp_pkg::t_reg_idx'(i_cfg_index))
                nclp_pkg::REG_B0: n_coef.b0 = $signed(i_cfg_data);
                nclp_pkg::REG_B1: n_coef.b1 = $signed(i_cfg_data);
                nclp_pkg::REG_B2: n_coef.b2 = $signed(i_cfg_data);
                nclp_pkg::REG_A1: n_coef.a1 = $signed(i_cfg_data);
                nclp_pkg::REG_A2: n_coef.a2 = $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_coef      = r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_coef.b0 <= nclp_pkg::COEF_B0_RST;
            r_coef.b1 <= nclp_pkg::COEF_B1_RST;
            r_coef.b2 <= nclp_pkg::COEF_B2_RST;
            r_coef.a1 <= nclp_pkg::COEF_A1_RST;
            r_coef.a2 <= nclp_pkg::COEF_A2_RST;
        end else begin
            r_v1   <= n_v1;
            r_v2   <= n_v2;
            r_v3   <= n_v3;
            r_coef <= n_coef;
        end
    end

    // A stalled feedback stage keeps its item
    `NCLP_ASSERT(a_hold_v3, i_clk, i_rst_n, (r_v3 && i_out_valid && !i_out_ready) |=> r_v3)
    // A transfer always lands in the product stage
    `NCLP_ASSERT(a_load_v1, i_clk, i_rst_n, o_ctl.load |=> r_v1)
    // A sum-stage item that cannot move stays
    `NCLP_ASSERT(a_hold_v2, i_clk, i_rst_n, (r_v2 && !o_ctl.mv3) |=> r_v2)
    // A b0 write shows up in the register
    `NCLP_ASSERT(a_cfg_b0, i_clk, i_rst_n,
        (i_cfg_valid && i_cfg_index == nclp_pkg::REG_B0) |=> (r_coef.b0 == $past(i_cfg_data)))

endmodule

`default_nettype wire

FILE: rtl/nclp_merge.sv
`default_nettype none

module nclp_merge (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_fire,
    input  logic [nclp_pkg::CHANNELS-1:0][nclp_pkg::SAMPLE_BITS-1:0] i_lane_y,
    input  logic                                                  i_out_ready,
    output logic                                                  o_out_valid,
    output logic [nclp_pkg::TDATA_W-1:0]                          o_out_data
);

    logic                                                 r_valid;
    logic [nclp_pkg::CHANNELS-1:0][nclp_pkg::SAMPLE_BITS-1:0] r_data;

    // Output register: all lanes land together
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_data <= i_lane_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Pack channels, first channel in the low bits, zero fill to bytes
    always_comb begin
        o_out_data                      = '0;
        o_out_data[nclp_pkg::DATA_W-1:0] = r_data;
    end

    assign o_out_valid = r_valid;

endmodule

`default_nettype wire

FILE: rtl/nine_channel_biquad_lowpass.sv
// Channel   | Direction | Transfer           | Payload
// s_axis    | in        | tvalid & tready    | nine 16-bit samples, tdata[143:0]
// m_axis    | out       | tvalid & tready    | nine 16-bit filtered samples
// cfg       | in        | i_cfg_valid & rdy  | index 0..4, 18-bit Q2.16 coefficient
//
// One item per clock sustained while m_axis_tready stays high; each input
// passes the product stage, feedforward sum stage and feedback stage into the
// output register. The feedback stage closes the one-item loop on y1.
// Reset is synchronous: history cleared, coefficients to their defaults.
// With m_axis_tready low a full output register holds and empty stages still fill;
// s_axis_tready falls only once all three stages are occupied.
`default_nettype none

module nine_channel_biquad_lowpass (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [nclp_pkg::TDATA_W-1:0]         s_axis_tdata,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [nclp_pkg::TDATA_W-1:0]         m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [nclp_pkg::REG_IDX_W-1:0]       i_cfg_index,
    input  logic [nclp_pkg::COEF_BITS-1:0]       i_cfg_data
);

    nclp_pkg::t_pipe_ctl ctl;
    nclp_pkg::t_coef     coef;
    logic [nclp_pkg::CHANNELS-1:0][nclp_pkg::SAMPLE_BITS-1:0] lane_y;

    nclp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ctl       (ctl),
        .o_coef      (coef)
    );

    // One biquad lane per channel
    for (genvar ch = 0; ch < nclp_pkg::CHANNELS; ch++) begin : g_lane
        nclp_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_coef  (coef),
            .i_x     (s_axis_tdata[ch*nclp_pkg::SAMPLE_BITS +: nclp_pkg::SAMPLE_BITS]),
            .o_y     (lane_y[ch])
        );
    end

    nclp_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (ctl.fire),
        .i_lane_y    (lane_y),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: bench/tb_nine_channel_biquad_lowpass.sv
`timescale 1ns / 1ps

module tb_nine_channel_biquad_lowpass;
    import nclp_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_WAIT       = 17;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 170;

    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    localparam logic [COEF_BITS-1:0] COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic [COEF_BITS-1:0] COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam logic [COEF_BITS-1:0] COEF_ZERO  = '0;
    localparam logic [COEF_BITS-1:0] COEF_UNITY = COEF_BITS'(1) << COEF_FRAC_BITS;
    localparam logic [COEF_BITS-1:0] COEF_HALF  = COEF_BITS'(1) << (COEF_FRAC_BITS - 1);

    // indexes above the last coefficient are not mapped to any register
    localparam logic [REG_IDX_W-1:0] FIRST_UNMAPPED_IDX = REG_IDX_W'(REG_A2) + 1'b1;

    localparam logic [SAMPLE_BITS-1:0] S_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] S_ONE  = SAMPLE_BITS'(1);
    localparam logic [SAMPLE_BITS-1:0] S_NEG1 = '1;
    localparam logic [SAMPLE_BITS-1:0] S_ZERO = '0;

    // idling styles per phase
    localparam int IDLE_NONE = 0;
    localparam int IDLE_FULL = 1;
    localparam int IDLE_RARE = 2;

    // channel k sits in bits [16k+15:16k]
    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] t_frame;

    localparam string CH_NAME [CHANNELS] = '{"accel_x", "accel_y", "accel_z",
                                             "gyro_x", "gyro_y", "gyro_z",
                                             "mag_x", "mag_y", "mag_z"};

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [TDATA_W-1:0]      s_axis_tdata = '0;
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]      m_axis_tdata;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [REG_IDX_W-1:0]    i_cfg_index = '0;
    logic [COEF_BITS-1:0]    i_cfg_data = '0;

    nine_channel_biquad_lowpass dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Filter state mirrored in the bench
    logic signed [COEF_BITS-1:0]   tap_b0 = COEF_B0_RST;
    logic signed [COEF_BITS-1:0]   tap_b1 = COEF_B1_RST;
    logic signed [COEF_BITS-1:0]   tap_b2 = COEF_B2_RST;
    logic signed [COEF_BITS-1:0]   fb_a1  = COEF_A1_RST;
    logic signed [COEF_BITS-1:0]   fb_a2  = COEF_A2_RST;
    logic signed [SAMPLE_BITS-1:0] hist_x1 [CHANNELS] = '{default: '0};
    logic signed [SAMPLE_BITS-1:0] hist_x2 [CHANNELS] = '{default: '0};
    logic signed [SAMPLE_BITS-1:0] hist_y1 [CHANNELS] = '{default: '0};
    logic signed [SAMPLE_BITS-1:0] hist_y2 [CHANNELS] = '{default: '0};

    t_frame sample_queue [$];
    t_frame filtered_due [$];
    int     walk_pos [CHANNELS] = '{default: 0};

    int total_queued = 0;
    int accepted_in  = 0;
    int results_seen = 0;
    int fail_count   = 0;
    int sat_count    = 0;
    int cfg_writes   = 0;
    int settings_run = 0;
    int send_mode    = IDLE_NONE;
    int recv_mode    = IDLE_NONE;
    int send_wait    = 0;
    int recv_wait    = 0;
    int quiet_cycles = 0;

    // Direct-form-I step on all channels; advances the mirrored history
    function automatic t_frame biquad_predict(t_frame x);
        t_frame y;
        longint acc;
        longint q;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            acc = longint'(tap_b0) * longint'($signed(x[ch]))
                + longint'(tap_b1) * longint'(hist_x1[ch])
                + longint'(tap_b2) * longint'(hist_x2[ch])
                - longint'(fb_a1) * longint'(hist_y1[ch])
                - longint'(fb_a2) * longint'(hist_y2[ch]);
            // half LSB then arithmetic shift: ties round up
            q = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            if (q > SAMPLE_MAX) begin
                q = SAMPLE_MAX;
                sat_count++;
            end else if (q < SAMPLE_MIN) begin
                q = SAMPLE_MIN;
                sat_count++;
            end
            y[ch] = q[SAMPLE_BITS-1:0];
            hist_x2[ch] = hist_x1[ch];
            hist_x1[ch] = $signed(x[ch]);
            hist_y2[ch] = hist_y1[ch];
            hist_y1[ch] = $signed(q[SAMPLE_BITS-1:0]);
        end
        return y;
    endfunction

    function automatic int draw_wait(int mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, MAX_WAIT);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
        endcase
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%t: %s", $realtime, msg);
        end
    endtask

    // Sender: presents queued frames, predicts on every input transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                filtered_due.push_back(biquad_predict(t_frame'(s_axis_tdata[DATA_W-1:0])));
                accepted_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    s_axis_tdata  <= TDATA_W'(sample_queue.pop_front());
                    s_axis_tvalid <= 1'b1;
                    send_wait = draw_wait(send_mode);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random backpressure, checks each output transfer per channel
    always @(posedge i_clk) begin
        t_frame got;
        t_frame want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_frame'(m_axis_tdata[DATA_W-1:0]);
                if (filtered_due.size() == 0) begin
                    report_failure($sformatf("result %0d with nothing pending: %h",
                                             results_seen, got));
                end else begin
                    want = filtered_due.pop_front();
                    for (int ch = 0; ch < CHANNELS; ch++) begin
                        if (got[ch] !== want[ch]) begin
                            report_failure($sformatf("result %0d %s: expected %0d got %0d",
                                results_seen, CH_NAME[ch], $signed(want[ch]),
                                $signed(got[ch])));
                        end
                    end
                end
                results_seen++;
                recv_wait = draw_wait(recv_mode);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d cycles without a transfer, %0d results pending",
                     quiet_cycles, filtered_due.size());
            $display("tb_nine_channel_biquad_lowpass: FAIL");
            $finish;
        end
    end

    // Register write over the config channel; mirror follows on the transfer
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COEF_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_B0:  tap_b0 = val;
            REG_B1:  tap_b1 = val;
            REG_B2:  tap_b2 = val;
            REG_A1:  fb_a1  = val;
            REG_A2:  fb_a2  = val;
            default: ;  // unmapped: no effect
        endcase
        cfg_writes++;
    endtask

    task automatic write_all(input logic [COEF_BITS-1:0] b0, input logic [COEF_BITS-1:0] b1,
                             input logic [COEF_BITS-1:0] b2, input logic [COEF_BITS-1:0] a1,
                             input logic [COEF_BITS-1:0] a2);
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
    endtask

    // Blocks until every queued frame has been accepted and has come back out
    task automatic wait_idle();
        do @(negedge i_clk); while (accepted_in != total_queued || filtered_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_frame(input t_frame f);
        sample_queue.push_back(f);
        total_queued++;
    endtask

    function automatic t_frame split_frame(logic [SAMPLE_BITS-1:0] even_v,
                                           logic [SAMPLE_BITS-1:0] odd_v);
        t_frame f;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            f[ch] = (ch % 2 == 0) ? even_v : odd_v;
        end
        return f;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] corner_sample();
        case ($urandom_range(0, 5))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return S_ZERO;
            3:       return S_ONE;
            4:       return S_NEG1;
            default: return S_MAX - 1'b1;
        endcase
    endfunction

    // Mostly slow random walks like real sensor traces, some noise and corners
    task automatic queue_random(input int count);
        t_frame f;
        int style;
        for (int n = 0; n < count; n++) begin
            style = $urandom_range(0, 99);
            for (int ch = 0; ch < CHANNELS; ch++) begin
                if (style < 55) begin
                    walk_pos[ch] += $urandom_range(0, 4095) - 2048;
                    if (walk_pos[ch] > SAMPLE_MAX) walk_pos[ch] = SAMPLE_MAX;
                    if (walk_pos[ch] < SAMPLE_MIN) walk_pos[ch] = SAMPLE_MIN;
                    f[ch] = walk_pos[ch][SAMPLE_BITS-1:0];
                end else if (style < 85) begin
                    f[ch] = SAMPLE_BITS'($urandom);
                end else begin
                    f[ch] = corner_sample();
                end
            end
            queue_frame(f);
        end
    endtask

    task automatic pick_idling();
        send_mode = $urandom_range(IDLE_NONE, IDLE_RARE);
        recv_mode = $urandom_range(IDLE_NONE, IDLE_RARE);
        settings_run++;
    endtask

    function automatic logic [COEF_BITS-1:0] near(logic [COEF_BITS-1:0] base);
        return base + COEF_BITS'($urandom_range(0, 1023)) - COEF_BITS'(512);
    endfunction

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset coefficients: steps to both rails, alternating rails, bit patterns, random frames
        pick_idling();
        queue_frame(split_frame(S_ZERO, S_ZERO));
        repeat (3) queue_frame(split_frame(S_MAX, S_MAX));
        repeat (3) queue_frame(split_frame(S_MIN, S_MIN));
        queue_frame(split_frame(S_MAX, S_MIN));
        queue_frame(split_frame(S_MIN, S_MAX));
        queue_frame(split_frame(S_ONE, S_ONE));
        queue_frame(split_frame(S_NEG1, S_NEG1));
        queue_frame(split_frame(SAMPLE_BITS'(16'h5555), SAMPLE_BITS'(16'hAAAA)));
        queue_frame(split_frame(SAMPLE_BITS'(16'hAAAA), SAMPLE_BITS'(16'h5555)));
        repeat (2) queue_frame(split_frame(S_ZERO, S_ZERO));
        queue_random(RANDOM_ITEMS);
        wait_idle();

        // Unity pass-through; unmapped indexes must leave it untouched
        pick_idling();
        write_all(COEF_UNITY, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
        for (int k = FIRST_UNMAPPED_IDX; k < (1 << REG_IDX_W); k++) begin
            write_reg(REG_IDX_W'(k), COEF_BITS'($urandom));
        end
        queue_frame(split_frame(S_MAX, S_MIN));
        queue_frame(split_frame(S_MIN, S_MAX));
        queue_frame(split_frame(S_ONE, S_NEG1));
        queue_frame(split_frame(S_ZERO, S_ONE));
        queue_random(RANDOM_ITEMS);
        wait_idle();

        // Two half taps (b0, b1): an odd sum of a sample and the one before lands on the rounding tie
        pick_idling();
        write_all(COEF_HALF, COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO);
        queue_random(RANDOM_ITEMS);
        wait_idle();

        // Coefficient rails: saturation in both directions
        pick_idling();
        write_all(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        queue_random(RANDOM_ITEMS);
        wait_idle();

        pick_idling();
        write_all(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
        queue_random(RANDOM_ITEMS);
        wait_idle();

        // Full-range random coefficients
        repeat (2) begin
            pick_idling();
            write_all(COEF_BITS'($urandom), COEF_BITS'($urandom), COEF_BITS'($urandom),
                      COEF_BITS'($urandom), COEF_BITS'($urandom));
            queue_random(RANDOM_ITEMS);
            wait_idle();
        end

        // Stable low-pass near the defaults
        pick_idling();
        write_all(near(COEF_B0_RST), near(COEF_B1_RST), near(COEF_B2_RST),
                  near(COEF_A1_RST), near(COEF_A2_RST));
        queue_random(RANDOM_ITEMS);
        wait_idle();

        // Defaults written back explicitly
        pick_idling();
        write_all(COEF_B0_RST, COEF_B1_RST, COEF_B2_RST, COEF_A1_RST, COEF_A2_RST);
        queue_random(RANDOM_ITEMS);
        wait_idle();

        $display("covered %0d sample frames and %0d filtered frames over %0d coefficient sets",
                 accepted_in, results_seen, settings_run);
        $display("%0d register writes, %0d saturated channel outputs, %0d failures",
                 cfg_writes, sat_count, fail_count);
        if (fail_count == 0 && filtered_due.size() == 0) begin
            $display("tb_nine_channel_biquad_lowpass: PASS");
        end else begin
            $display("tb_nine_channel_biquad_lowpass: FAIL");
        end
        $finish;
    end

endmodule
